// ----- sv/esc_pkg.sv -----
// shared types, constants and arithmetic helpers for the sensor compensation core
`default_nettype none
package esc_pkg;

  localparam int unsigned DivStages = 32;

  localparam logic [31:0] Off64000   = 32'd64000;
  localparam logic [31:0] Full20     = 32'd1048576;
  localparam logic [31:0] Scale3125  = 32'd3125;
  localparam logic [31:0] SignBit    = 32'h8000_0000;
  localparam logic [31:0] One15      = 32'd32768;
  localparam logic [31:0] Off76800   = 32'd76800;
  localparam logic [31:0] Round14    = 32'd16384;
  localparam logic [31:0] Off2097152 = 32'd2097152;
  localparam logic [31:0] Round13    = 32'd8192;
  localparam logic [31:0] HumMax     = 32'd419430400;

  typedef enum logic [2:0] {
    CFG_TEMP       = 3'd0,
    CFG_PRESS_LOW  = 3'd1,
    CFG_PRESS_HIGH = 3'd2,
    CFG_PRESS_NINE = 3'd3,
    CFG_HUM_LOW    = 3'd4,
    CFG_HUM_HIGH   = 3'd5
  } cfg_idx_e;

  // calibration coefficients, extended to 32 bits
  typedef struct packed {
    logic [31:0] t1, t2, t3;
    logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] h1, h2, h3, h4, h5, h6;
  } coef_t;

  // data that rides alongside the divider
  typedef struct packed {
    logic [31:0] temp;
    logic [16:0] hum;
    logic        ok;
    logic        dbl;
  } side_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] num;
    logic [31:0] quo;
    logic [31:0] dv;
    side_t       side;
  } div_t;

  typedef struct packed {
    logic [31:0] temp;
    logic [31:0] press;
    logic [16:0] hum;
    logic        ok;
  } res_t;

  function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = a * b;
    return p[31:0];
  endfunction

  function automatic logic [31:0] sra32(input logic [31:0] x, input logic [4:0] n);
    return $signed(x) >>> n;
  endfunction

endpackage
`default_nettype wire

// ----- sv/esc_if.sv -----
// request channels for raw readings and compensated results
`default_nettype none
interface esc_in_if;
  logic        valid;
  logic        ready;
  logic [19:0] raw_temperature;
  logic [19:0] raw_pressure;
  logic [15:0] raw_humidity;
  modport source (output valid, raw_temperature, raw_pressure, raw_humidity, input ready);
  modport sink (input valid, raw_temperature, raw_pressure, raw_humidity, output ready);
endinterface

interface esc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] temperature_centi;
  logic        [31:0] pressure_pa;
  logic        [16:0] humidity_q10;
  logic               result_valid;
  modport source (output valid, temperature_centi, pressure_pa, humidity_q10, result_valid,
                  input ready);
  modport sink (input valid, temperature_centi, pressure_pa, humidity_q10, result_valid,
                output ready);
endinterface
`default_nettype wire

// ----- sv/esc_front.sv -----
// temperature, pressure pre-division and humidity pipeline stages
`default_nettype none
module esc_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          adv_i,
  input  wire logic          valid_i,
  input  wire logic [19:0]   raw_t_i,
  input  wire logic [19:0]   raw_p_i,
  input  wire logic [15:0]   raw_h_i,
  input  wire esc_pkg::coef_t coef_i,
  output logic               valid_o,
  output esc_pkg::div_t      div_o
);
  import esc_pkg::*;

  logic [10:0] v_q;

  logic [31:0] m1_q, m2_q, up1_q, up2_q, up3_q, up4_q, up5_q, up6_q;
  logic [15:0] uh1_q, uh2_q, uh3_q, uh4_q;
  logic [31:0] ta_q, m3_q, tf_q;
  logic [31:0] qq_q, ap5_q, p2a_q, mt5_q, h5d_q, dh6_q, dh3_q;
  logic [31:0] b1_q, c1_q, ap5b_q, p2ab_q, temp5_q, mh_q, ha5_q;
  logic [31:0] pb_q, a2_q, mh2_q, temp6_q, ha6_q;
  logic [31:0] mk_q, prm_q, hbb_q, temp7_q, ha7_q;
  logic [31:0] dv8_q, prm8_q, hd2_q, temp8_q;
  logic [31:0] dv9_q, prm9_q, hd9_q, ss_q, temp9_q;
  logic [31:0] dv10_q, prm10_q, hd10_q, th_q, temp10_q;
  div_t        out_q;

  logic [31:0] x1, d0, pa, qv, hd, hs, hdd, dq;

  always_comb begin
    x1  = {15'd0, raw_t_i[19:3]} - {coef_i.t1[30:0], 1'b0};
    d0  = {16'd0, raw_t_i[19:4]} - coef_i.t1;
    pa  = sra32(tf_q, 5'd1) - Off64000;
    qv  = sra32(pa, 5'd2);
    hd  = tf_q - Off76800;
    hs  = sra32(hd2_q, 5'd15);
    hdd = hd10_q - sra32(th_q, 5'd4);
    if (hdd[31]) begin
      dq = '0;
    end else if (hdd > HumMax) begin
      dq = HumMax;
    end else begin
      dq = hdd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[9:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      m1_q  <= mul32(x1, coef_i.t2);
      m2_q  <= mul32(d0, d0);
      up1_q <= {12'd0, raw_p_i};
      uh1_q <= raw_h_i;

      ta_q  <= sra32(m1_q, 5'd11);
      m3_q  <= mul32(sra32(m2_q, 5'd12), coef_i.t3);
      up2_q <= up1_q;
      uh2_q <= uh1_q;

      tf_q  <= ta_q + sra32(m3_q, 5'd14);
      up3_q <= up2_q;
      uh3_q <= uh2_q;

      qq_q  <= mul32(qv, qv);
      ap5_q <= mul32(pa, coef_i.p5);
      p2a_q <= mul32(coef_i.p2, pa);
      mt5_q <= mul32(tf_q, 32'd5);
      h5d_q <= mul32(coef_i.h5, hd);
      dh6_q <= mul32(hd, coef_i.h6);
      dh3_q <= mul32(hd, coef_i.h3);
      up4_q <= up3_q;
      uh4_q <= uh3_q;

      b1_q    <= mul32(sra32(qq_q, 5'd11), coef_i.p6);
      c1_q    <= mul32(coef_i.p3, sra32(qq_q, 5'd13));
      ap5b_q  <= ap5_q;
      p2ab_q  <= p2a_q;
      temp5_q <= sra32(mt5_q + 32'd128, 5'd8);
      mh_q    <= mul32(sra32(dh6_q, 5'd10), sra32(dh3_q, 5'd11) + One15);
      ha5_q   <= sra32((({2'd0, uh4_q, 14'd0}) - {coef_i.h4[11:0], 20'd0} - h5d_q)
                       + Round14, 5'd15);
      up5_q   <= up4_q;

      pb_q    <= sra32(b1_q + {ap5b_q[30:0], 1'b0}, 5'd2) + {coef_i.p4[15:0], 16'd0};
      a2_q    <= sra32(sra32(c1_q, 5'd3) + sra32(p2ab_q, 5'd1), 5'd18);
      mh2_q   <= mul32(sra32(mh_q, 5'd10) + Off2097152, coef_i.h2);
      temp6_q <= temp5_q;
      ha6_q   <= ha5_q;
      up6_q   <= up5_q;

      mk_q    <= mul32(One15 + a2_q, coef_i.p1);
      prm_q   <= mul32((Full20 - up6_q) - sra32(pb_q, 5'd12), Scale3125);
      hbb_q   <= sra32(mh2_q + Round13, 5'd14);
      temp7_q <= temp6_q;
      ha7_q   <= ha6_q;

      dv8_q   <= sra32(mk_q, 5'd15);
      prm8_q  <= prm_q;
      hd2_q   <= mul32(ha7_q, hbb_q);
      temp8_q <= temp7_q;

      dv9_q   <= dv8_q;
      prm9_q  <= prm8_q;
      hd9_q   <= hd2_q;
      ss_q    <= mul32(hs, hs);
      temp9_q <= temp8_q;

      dv10_q   <= dv9_q;
      prm10_q  <= prm9_q;
      hd10_q   <= hd9_q;
      th_q     <= mul32(sra32(ss_q, 5'd7), coef_i.h1);
      temp10_q <= temp9_q;

      out_q.rem       <= '0;
      out_q.quo       <= '0;
      out_q.dv        <= dv10_q;
      out_q.num       <= (prm10_q < SignBit) ? {prm10_q[30:0], 1'b0} : prm10_q;
      out_q.side.dbl  <= !(prm10_q < SignBit);
      out_q.side.ok   <= (dv10_q != '0);
      out_q.side.temp <= temp10_q;
      out_q.side.hum  <= dq[28:12];
    end
  end

  assign valid_o = v_q[10];
  assign div_o   = out_q;
endmodule
`default_nettype wire

// ----- sv/esc_div.sv -----
// pipelined restoring divider, one quotient bit per stage
`default_nettype none
module esc_div (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          adv_i,
  input  wire logic          valid_i,
  input  wire esc_pkg::div_t div_i,
  output logic               valid_o,
  output esc_pkg::div_t      div_o
);
  import esc_pkg::*;

  div_t stg_q [DivStages];
  logic vld_q [DivStages];
  div_t stg_in [DivStages];
  logic vld_in [DivStages];

  assign stg_in[0] = div_i;
  assign vld_in[0] = valid_i;

  for (genvar k = 0; k < DivStages; k++) begin : g_stage
    logic [32:0] sr;
    logic        ge;
    div_t        nx;

    if (k > 0) begin : g_link
      assign stg_in[k] = stg_q[k-1];
      assign vld_in[k] = vld_q[k-1];
    end

    always_comb begin
      sr = {stg_in[k].rem, stg_in[k].num[31]};
      ge = (sr >= {1'b0, stg_in[k].dv});
      nx = stg_in[k];
      nx.num = {stg_in[k].num[30:0], 1'b0};
      nx.quo = {stg_in[k].quo[30:0], ge};
      nx.rem = ge ? 32'(sr - {1'b0, stg_in[k].dv}) : sr[31:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (adv_i) begin
        vld_q[k] <= vld_in[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        stg_q[k] <= nx;
      end
    end
  end

  assign valid_o = vld_q[DivStages-1];
  assign div_o   = stg_q[DivStages-1];
endmodule
`default_nettype wire

// ----- sv/esc_back.sv -----
// pressure correction after division and the result register
`default_nettype none
module esc_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           adv_i,
  input  wire logic           valid_i,
  input  wire esc_pkg::div_t  div_i,
  input  wire esc_pkg::coef_t coef_i,
  output logic                valid_o,
  output esc_pkg::res_t       res_o
);
  import esc_pkg::*;

  logic [2:0]  v_q;
  logic [31:0] pr1_q, m1_q, m2_q, pr2_q, m2b_q, m3_q;
  side_t       s1_q, s2_q;
  res_t        res_q;
  logic [31:0] pr0, pa, pb, pf;

  always_comb begin
    pr0 = div_i.side.dbl ? {div_i.quo[30:0], 1'b0} : div_i.quo;
    pa  = sra32(m3_q, 5'd12);
    pb  = sra32(m2b_q, 5'd13);
    pf  = pr2_q + sra32(pa + pb + coef_i.p7, 5'd4);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      pr1_q <= pr0;
      m1_q  <= mul32({3'd0, pr0[31:3]}, {3'd0, pr0[31:3]});
      m2_q  <= mul32({2'd0, pr0[31:2]}, coef_i.p8);
      s1_q  <= div_i.side;

      pr2_q <= pr1_q;
      m2b_q <= m2_q;
      m3_q  <= mul32(coef_i.p9, {13'd0, m1_q[31:13]});
      s2_q  <= s1_q;

      res_q.temp  <= s2_q.temp;
      res_q.ok    <= s2_q.ok;
      res_q.press <= s2_q.ok ? pf : '0;
      res_q.hum   <= s2_q.ok ? s2_q.hum : '0;
    end
  end

  assign valid_o = v_q[2];
  assign res_o   = res_q;
endmodule
`default_nettype wire

// ----- sv/env_sensor_compensation_core.sv -----
// top level of the sensor compensation core: coefficient registers and pipeline
//
//  channel  | dir | payload
//  in_req   | in  | raw_temperature, raw_pressure, raw_humidity
//  out_res  | out | temperature_centi, pressure_pa, humidity_q10, result_valid
//  cfg      | in  | cfg_we_i, cfg_idx_i, cfg_data_i
//
// one request per cycle unless a held result stalls the pipeline; front, divider and back stages in that order
// the divider takes one quotient bit per stage, which sets the depth
// reset clears the coefficients and all stage valid bits
// a held result stalls every stage together; bubbles flow through
`default_nettype none
module env_sensor_compensation_core (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  esc_in_if.sink     in_req,
  esc_out_if.source  out_res,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [63:0] cfg_data_i
);
  import esc_pkg::*;

  logic [47:0] temp_q;
  logic [63:0] pl_q, ph_q;
  logic [15:0] p9_q;
  logic [31:0] hl_q, hh_q;
  coef_t       coef;
  logic        adv, fr_v, dv_v, bk_v;
  div_t        fr_d, dv_d;
  res_t        res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_q <= '0;
      pl_q   <= '0;
      ph_q   <= '0;
      p9_q   <= '0;
      hl_q   <= '0;
      hh_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_TEMP:       temp_q <= cfg_data_i[47:0];
        CFG_PRESS_LOW:  pl_q   <= cfg_data_i;
        CFG_PRESS_HIGH: ph_q   <= cfg_data_i;
        CFG_PRESS_NINE: p9_q   <= cfg_data_i[15:0];
        CFG_HUM_LOW:    hl_q   <= cfg_data_i[31:0];
        CFG_HUM_HIGH:   hh_q   <= cfg_data_i[31:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    coef.t1 = {16'd0, temp_q[15:0]};
    coef.t2 = {{16{temp_q[31]}}, temp_q[31:16]};
    coef.t3 = {{16{temp_q[47]}}, temp_q[47:32]};
    coef.p1 = {16'd0, pl_q[15:0]};
    coef.p2 = {{16{pl_q[31]}}, pl_q[31:16]};
    coef.p3 = {{16{pl_q[47]}}, pl_q[47:32]};
    coef.p4 = {{16{pl_q[63]}}, pl_q[63:48]};
    coef.p5 = {{16{ph_q[15]}}, ph_q[15:0]};
    coef.p6 = {{16{ph_q[31]}}, ph_q[31:16]};
    coef.p7 = {{16{ph_q[47]}}, ph_q[47:32]};
    coef.p8 = {{16{ph_q[63]}}, ph_q[63:48]};
    coef.p9 = {{16{p9_q[15]}}, p9_q};
    coef.h1 = {24'd0, hl_q[7:0]};
    coef.h2 = {{16{hl_q[23]}}, hl_q[23:8]};
    coef.h3 = {24'd0, hl_q[31:24]};
    coef.h4 = {{20{hh_q[11]}}, hh_q[11:0]};
    coef.h5 = {{20{hh_q[23]}}, hh_q[23:12]};
    coef.h6 = {{24{hh_q[31]}}, hh_q[31:24]};
  end

  assign adv          = !bk_v || out_res.ready;
  assign in_req.ready = adv;

  esc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (in_req.valid),
    .raw_t_i (in_req.raw_temperature),
    .raw_p_i (in_req.raw_pressure),
    .raw_h_i (in_req.raw_humidity),
    .coef_i  (coef),
    .valid_o (fr_v),
    .div_o   (fr_d)
  );

  esc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (fr_v),
    .div_i   (fr_d),
    .valid_o (dv_v),
    .div_o   (dv_d)
  );

  esc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (dv_v),
    .div_i   (dv_d),
    .coef_i  (coef),
    .valid_o (bk_v),
    .res_o   (res)
  );

  assign out_res.valid             = bk_v;
  assign out_res.temperature_centi = res.temp;
  assign out_res.pressure_pa       = res.press;
  assign out_res.humidity_q10      = res.hum;
  assign out_res.result_valid      = res.ok;
endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
// self-checking testbench for the sensor compensation core with a result scoreboard
`default_nettype none
class comp_scoreboard;
  logic [63:0] coeff_reg [6];
  logic [31:0] exp_temp [$];
  logic [31:0] exp_press [$];
  logic [16:0] exp_hum [$];
  logic        exp_ok [$];
  int errors;

  function new();
    foreach (coeff_reg[i]) coeff_reg[i] = '0;
    errors = 0;
  endfunction

  function void write_coeff(logic [2:0] idx, logic [63:0] val);
    case (idx)
      esc_pkg::CFG_TEMP:       coeff_reg[idx] = {16'd0, val[47:0]};
      esc_pkg::CFG_PRESS_LOW:  coeff_reg[idx] = val;
      esc_pkg::CFG_PRESS_HIGH: coeff_reg[idx] = val;
      esc_pkg::CFG_PRESS_NINE: coeff_reg[idx] = {48'd0, val[15:0]};
      esc_pkg::CFG_HUM_LOW:    coeff_reg[idx] = {32'd0, val[31:0]};
      esc_pkg::CFG_HUM_HIGH:   coeff_reg[idx] = {32'd0, val[31:0]};
      default: ;
    endcase
  endfunction

  static function logic [31:0] asr(logic [31:0] x, int n);
    return $signed(x) >>> n;
  endfunction

  static function logic [31:0] m32(logic [31:0] a, logic [31:0] b);
    logic [63:0] p;
    p = a * b;
    return p[31:0];
  endfunction

  function void note_request(logic [19:0] ut_raw, logic [19:0] up_raw, logic [15:0] uh_raw);
    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] h1, h2, h3, h4, h5, h6, ut, up, uh;
    logic [31:0] a, b, d, tf, temp, pr, hum, sa;
    logic        ok;
    t1 = {16'd0, coeff_reg[0][15:0]};
    t2 = {{16{coeff_reg[0][31]}}, coeff_reg[0][31:16]};
    t3 = {{16{coeff_reg[0][47]}}, coeff_reg[0][47:32]};
    p1 = {16'd0, coeff_reg[1][15:0]};
    p2 = {{16{coeff_reg[1][31]}}, coeff_reg[1][31:16]};
    p3 = {{16{coeff_reg[1][47]}}, coeff_reg[1][47:32]};
    p4 = {{16{coeff_reg[1][63]}}, coeff_reg[1][63:48]};
    p5 = {{16{coeff_reg[2][15]}}, coeff_reg[2][15:0]};
    p6 = {{16{coeff_reg[2][31]}}, coeff_reg[2][31:16]};
    p7 = {{16{coeff_reg[2][47]}}, coeff_reg[2][47:32]};
    p8 = {{16{coeff_reg[2][63]}}, coeff_reg[2][63:48]};
    p9 = {{16{coeff_reg[3][15]}}, coeff_reg[3][15:0]};
    h1 = {24'd0, coeff_reg[4][7:0]};
    h2 = {{16{coeff_reg[4][23]}}, coeff_reg[4][23:8]};
    h3 = {24'd0, coeff_reg[4][31:24]};
    h4 = {{20{coeff_reg[5][11]}}, coeff_reg[5][11:0]};
    h5 = {{20{coeff_reg[5][23]}}, coeff_reg[5][23:12]};
    h6 = {{24{coeff_reg[5][31]}}, coeff_reg[5][31:24]};
    ut = {12'd0, ut_raw};
    up = {12'd0, up_raw};
    uh = {16'd0, uh_raw};
    pr = 0;
    hum = 0;
    ok = 0;
    a = asr(m32((ut >> 3) - (t1 << 1), t2), 11);
    d = (ut >> 4) - t1;
    b = asr(m32(asr(m32(d, d), 12), t3), 14);
    tf = a + b;
    temp = asr(m32(tf, 5) + 128, 8);
    a = asr(tf, 1) - 32'd64000;
    sa = asr(a, 2);
    b = m32(asr(m32(sa, sa), 11), p6);
    b = b + (m32(a, p5) << 1);
    b = asr(b, 2) + (p4 << 16);
    a = asr(asr(m32(p3, asr(m32(sa, sa), 13)), 3) + asr(m32(p2, a), 1), 18);
    a = asr(m32(32'd32768 + a, p1), 15);
    if (a != 0) begin
      ok = 1;
      pr = m32((32'd1048576 - up) - asr(b, 12), 32'd3125);
      if (pr < 32'h8000_0000) pr = (pr << 1) / a;
      else pr = (pr / a) * 2;
      a = asr(m32(p9, m32(pr >> 3, pr >> 3) >> 13), 12);
      b = asr(m32(pr >> 2, p8), 13);
      pr = pr + asr(a + b + p7, 4);
      d = tf - 32'd76800;
      a = asr(((uh << 14) - (h4 << 20) - m32(h5, d)) + 32'd16384, 15);
      b = asr(m32(asr(m32(d, h6), 10), asr(m32(d, h3), 11) + 32'd32768), 10);
      b = asr(m32(b + 32'd2097152, h2) + 32'd8192, 14);
      d = m32(a, b);
      d = d - asr(m32(asr(m32(asr(d, 15), asr(d, 15)), 7), h1), 4);
      if (d[31]) d = 0;
      if (d > 32'd419430400) d = 32'd419430400;
      hum = d >> 12;
    end
    exp_temp.push_back(temp);
    exp_press.push_back(pr);
    exp_hum.push_back(hum[16:0]);
    exp_ok.push_back(ok);
  endfunction

  function void check_result(logic [31:0] t, logic [31:0] p, logic [16:0] h, logic v);
    if (exp_temp.size() == 0) begin
      $display("%0t: unexpected result t=%0h p=%0h h=%0h v=%0b", $time, t, p, h, v);
      errors++;
      return;
    end
    if (exp_temp[0] !== t) begin
      $display("%0t: temperature exp %0h got %0h", $time, exp_temp[0], t);
      errors++;
    end
    if (exp_press[0] !== p) begin
      $display("%0t: pressure exp %0h got %0h", $time, exp_press[0], p);
      errors++;
    end
    if (exp_hum[0] !== h) begin
      $display("%0t: humidity exp %0h got %0h", $time, exp_hum[0], h);
      errors++;
    end
    if (exp_ok[0] !== v) begin
      $display("%0t: valid flag exp %0b got %0b", $time, exp_ok[0], v);
      errors++;
    end
    void'(exp_temp.pop_front());
    void'(exp_press.pop_front());
    void'(exp_hum.pop_front());
    void'(exp_ok.pop_front());
  endfunction
endclass

module tb_top;
  import esc_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [63:0] cfg_data_i;
  longint      cycle_count;
  comp_scoreboard sb;

  esc_in_if  in_req ();
  esc_out_if out_res ();

  env_sensor_compensation_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_req     (in_req.sink),
    .out_res    (out_res.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  task automatic write_coeff(cfg_idx_e idx, logic [63:0] val);
    cfg_we_i   <= 1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    sb.write_coeff(idx, val);
    @(posedge clk_i);
  endtask

  task automatic send_reading(logic [19:0] ut, logic [19:0] up, logic [15:0] uh, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_req.valid <= 0;
      repeat (g) @(posedge clk_i);
    end
    in_req.valid           <= 1;
    in_req.raw_temperature <= ut;
    in_req.raw_pressure    <= up;
    in_req.raw_humidity    <= uh;
    do @(posedge clk_i); while (!in_req.ready);
    sb.note_request(ut, up, uh);
  endtask

  task automatic drain();
    in_req.valid <= 0;
    while (sb.exp_temp.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic load_typical();
    write_coeff(CFG_TEMP, {16'd0, 16'd50, 16'd26435, 16'd27504});
    write_coeff(CFG_PRESS_LOW, {16'd2855, 16'd3024, 16'hd63d, 16'd36477});
    write_coeff(CFG_PRESS_HIGH, {16'hdd8b, 16'd15500, 16'hfff9, 16'd140});
    write_coeff(CFG_PRESS_NINE, 64'd6000);
    write_coeff(CFG_HUM_LOW, {32'd0, 8'd0, 16'd359, 8'd75});
    write_coeff(CFG_HUM_HIGH, {32'd0, 8'd30, 12'd50, 12'd340});
    cfg_we_i <= 0;
  endtask

  task automatic load_random();
    write_coeff(CFG_TEMP, {$urandom, $urandom});
    write_coeff(CFG_PRESS_LOW, {$urandom, $urandom});
    write_coeff(CFG_PRESS_HIGH, {$urandom, $urandom});
    write_coeff(CFG_PRESS_NINE, {$urandom, $urandom});
    write_coeff(CFG_HUM_LOW, {$urandom, $urandom});
    write_coeff(CFG_HUM_HIGH, {$urandom, $urandom});
    cfg_we_i <= 0;
  endtask

  task automatic load_fill(logic [63:0] v);
    write_coeff(CFG_TEMP, v);
    write_coeff(CFG_PRESS_LOW, v);
    write_coeff(CFG_PRESS_HIGH, v);
    write_coeff(CFG_PRESS_NINE, v);
    write_coeff(CFG_HUM_LOW, v);
    write_coeff(CFG_HUM_HIGH, v);
    cfg_we_i <= 0;
  endtask

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0)
        send_reading(20'($urandom), 20'($urandom), 16'($urandom), i % 100 < 70);
      else
        send_reading(20'($urandom_range(400000, 600000)),
                     20'($urandom_range(250000, 450000)),
                     16'($urandom_range(20000, 40000)), i % 100 < 70);
    end
    drain();
  endtask

  // result side: random back-pressure with quiet stretches
  initial begin
    int stall;
    out_res.ready <= 0;
    @(posedge rst_ni);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : gap_len();
      if (stall > 0) begin
        out_res.ready <= 0;
        repeat (stall) @(posedge clk_i);
      end
      out_res.ready <= 1;
      @(posedge clk_i);
      if (out_res.valid)
        sb.check_result(out_res.temperature_centi, out_res.pressure_pa,
                        out_res.humidity_q10, out_res.result_valid);
    end
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > 400000) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    sb = new();
    rst_ni = 0;
    cfg_we_i = 0;
    cfg_idx_i = 0;
    cfg_data_i = 0;
    in_req.valid = 0;
    in_req.raw_temperature = 0;
    in_req.raw_pressure = 0;
    in_req.raw_humidity = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // all-zero coefficients: divisor zero, invalid results
    send_reading(0, 0, 0, 0);
    send_reading(20'hfffff, 20'hfffff, 16'hffff, 0);
    drain();
    load_typical();
    send_reading(20'd519888, 20'd415148, 16'd30000, 0);
    send_reading(0, 0, 0, 0);
    send_reading(20'hfffff, 20'hfffff, 16'hffff, 0);
    send_reading(0, 20'hfffff, 16'hffff, 0);
    send_reading(20'hfffff, 0, 0, 0);
    send_reading(20'd519888, 20'd415148, 16'hffff, 0);
    send_reading(20'd519888, 20'd415148, 16'd0, 0);
    send_reading(20'haaaaa, 20'h55555, 16'haaaa, 0);
    send_reading(20'h55555, 20'haaaaa, 16'h5555, 0);
    drain();
    load_fill('1);
    send_reading(0, 0, 0, 0);
    send_reading(20'hfffff, 20'hfffff, 16'hffff, 0);
    drain();
    load_fill(64'h8000_8000_8000_8000);
    send_reading(20'h80000, 20'h80000, 16'h8000, 0);
    send_reading(20'hfffff, 0, 16'hffff, 0);
    drain();
    load_typical();
    random_phase(400);
    for (int k = 0; k < 3; k++) begin
      load_random();
      random_phase(100);
    end
    if (sb.errors == 0 && sb.exp_temp.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
`default_nettype wire
